@@ hw/rtl/led_ring_spot_renderer_unit_defines.svh @@
// Assertion macros shared by the checker files of the LED ring spot renderer.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef LED_RING_SPOT_RENDERER_UNIT_DEFINES_SVH
`define LED_RING_SPOT_RENDERER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LRSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LRSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lrsr_pkg.sv @@
// Package of the LED ring spot renderer: sizes, codes and small helper functions.
// Used by the top level and the checker; depends on nothing.
package lrsr_pkg;

   // Store geometry and position scaling
   localparam int STORE_DEPTH    = 256;
   localparam int POSITION_SHIFT = 12;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int CHAN_W         = 8;
   localparam int PIX_W          = 3 * CHAN_W;

   // Pixel counter: ring start + offset + count, and start + length, all fit
   localparam int PX_W  = $clog2(512 + (2 << (16 - POSITION_SHIFT)));
   localparam int EXT_W = (ADDR_W > PX_W) ? ADDR_W : PX_W;
   localparam int CNT_W = 9;

   // Port widths
   localparam int REQ_DATA_W  = 80;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hff;
   localparam logic [CHAN_W-1:0] BRIGHT_FULL = 8'hff;
   localparam logic [8:0]        RING_LENGTH_RESET = 9'd16;

   typedef enum logic [REQ_USER_W-1:0] {
      REQ_CLEAR      = 2'd0,
      REQ_SPOT       = 2'd1,
      REQ_BACKGROUND = 2'd2,
      REQ_READ       = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RING_START  = 1'b0,
      CSR_RING_LENGTH = 1'b1
   } csr_index_type;

   // Per-channel saturating add
   function automatic logic [CHAN_W-1:0] sat_add8(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CHAN_W] ? CHAN_MAX : s[CHAN_W-1:0];
   endfunction

   // Pixel counter to store address, modulo the store depth
   function automatic logic [ADDR_W-1:0] to_addr(input logic [PX_W-1:0] px);
      logic [EXT_W-1:0] e;
      e = EXT_W'(px);
      return e[ADDR_W-1:0];
   endfunction

endpackage

@@ hw/rtl/led_ring_spot_renderer_unit.sv @@
// LED ring spot renderer: a 256-pixel RGB store in one RAM, drawn on one ring segment
// at a time. Depends on lrsr_pkg and lrsr_ram.
//
// One request is worked at a time; the store has a single write port, so the pixels
// touched are written one by one. Clear and background write each ring pixel, a
// replacing spot writes count pixels, an adding spot reads, then writes back each of
// its count pixels, with count = spot_width >> 12. The next request is taken while
// the previous result still waits on the response side. After reset a clearing pass
// writes every store entry to black; requests are held off until it ends,
// configuration writes are taken throughout.
module led_ring_spot_renderer_unit (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata from bit 0 up: spot_pos[16], spot_width[16], red[8], green[8], blue[8],
   // blend_add[1], brightness[8], pixel_index[8], zero padding[7]
   input  logic [lrsr_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: req_type[2]
   input  logic [lrsr_pkg::REQ_USER_W-1:0] req_tuser,
   // Response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata from bit 0 up: read_red[8], read_green[8], read_blue[8]
   output logic [lrsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lrsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lrsr_pkg::CSR_DATA_W-1:0]  csr_data
);

   import lrsr_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_FILL,
      S_SPOT_WR,
      S_ADD_RD,
      S_ADD_WR,
      S_READ,
      S_DONE
   } state_type;

   // Registers
   state_type          state_ff,      state_in;
   logic [ADDR_W-1:0]  init_addr_ff,  init_addr_in;
   logic [7:0]         ring_start_ff, ring_start_in;
   logic [8:0]         ring_length_ff, ring_length_in;
   logic [PX_W-1:0]    px_ff,         px_in;
   logic [CNT_W-1:0]   rem_ff,        rem_in;
   logic [PIX_W-1:0]   colour_ff,     colour_in;
   logic [PIX_W-1:0]   result_ff,     result_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request fields
   logic [15:0]        spot_pos, spot_width;
   logic [CHAN_W-1:0]  red, green, blue, brightness;
   logic               blend_add;
   logic [7:0]         pixel_index;
   req_kind_type       req_type;

   // Datapath
   logic [15:0]        spot_diff;
   logic [PX_W-1:0]    spot_offset;
   logic [CNT_W-1:0]   spot_count;
   logic [15:0]        prod_r, prod_g, prod_b;
   logic [PIX_W-1:0]   bg_colour;
   logic [PX_W-1:0]    wrap_at, px_step, spot_next;
   logic [PIX_W-1:0]   added;
   logic               req_xfer, last_px;

   // Memory port
   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [PIX_W-1:0]   ram_wr_data, ram_rd_data;

   lrsr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Unpack the request
   assign spot_pos    = req_tdata[15:0];
   assign spot_width  = req_tdata[31:16];
   assign red         = req_tdata[39:32];
   assign green       = req_tdata[47:40];
   assign blue        = req_tdata[55:48];
   assign blend_add   = req_tdata[56];
   assign brightness  = req_tdata[64:57];
   assign pixel_index = req_tdata[72:65];
   assign req_type    = req_kind_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Spot geometry
   assign spot_diff   = spot_pos - {1'b0, spot_width[15:1]};
   assign spot_offset = PX_W'(spot_diff >> POSITION_SHIFT);
   assign spot_count  = CNT_W'(spot_width >> POSITION_SHIFT);

   // Background scaling, registered into the colour
   assign prod_r    = brightness * red;
   assign prod_g    = brightness * green;
   assign prod_b    = brightness * blue;
   assign bg_colour = (brightness < BRIGHT_FULL) ?
                      {prod_r[15:8], prod_g[15:8], prod_b[15:8]} : {red, green, blue};

   // Pixel counter step, with the wrap back to the ring start for spots
   assign wrap_at   = PX_W'(ring_start_ff) + PX_W'(ring_length_ff);
   assign px_step   = px_ff + PX_W'(1);
   assign spot_next = (px_step == wrap_at) ? PX_W'(ring_start_ff) : px_step;
   assign last_px   = (rem_ff == CNT_W'(1));

   assign added = {sat_add8(ram_rd_data[23:16], colour_ff[23:16]),
                   sat_add8(ram_rd_data[15:8],  colour_ff[15:8]),
                   sat_add8(ram_rd_data[7:0],   colour_ff[7:0])};

   // Sequencer and memory control
   always_comb begin
      state_in       = state_ff;
      init_addr_in   = init_addr_ff;
      ring_start_in  = ring_start_ff;
      ring_length_in = ring_length_ff;
      px_in          = px_ff;
      rem_in         = rem_ff;
      colour_in      = colour_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = to_addr(px_ff);
      ram_wr_data    = colour_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = to_addr(px_ff);

      // Take configuration writes
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RING_START:  ring_start_in  = csr_data[7:0];
            CSR_RING_LENGTH: ring_length_in = csr_data;
            default:         ;
         endcase
      end

      case (state_ff)
         S_INIT: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = init_addr_ff;
            ram_wr_data  = '0;
            init_addr_in = init_addr_ff + ADDR_W'(1);
            if (init_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               result_in = '0;
               case (req_type)
                  REQ_CLEAR, REQ_BACKGROUND: begin
                     px_in     = PX_W'(ring_start_ff);
                     rem_in    = ring_length_ff;
                     colour_in = (req_type == REQ_CLEAR) ? '0 : bg_colour;
                     state_in  = (ring_length_ff == '0) ? S_DONE : S_FILL;
                  end
                  REQ_SPOT: begin
                     px_in     = PX_W'(ring_start_ff) + spot_offset;
                     rem_in    = spot_count;
                     colour_in = {red, green, blue};
                     if (spot_count == '0) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = blend_add ? S_ADD_RD : S_SPOT_WR;
                     end
                  end
                  default: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = to_addr(PX_W'(pixel_index));
                     state_in    = S_READ;
                  end
               endcase
            end
         end
         S_FILL: begin
            ram_wr_en = 1'b1;
            px_in     = px_step;
            rem_in    = rem_ff - CNT_W'(1);
            if (last_px) begin
               state_in = S_DONE;
            end
         end
         S_SPOT_WR: begin
            ram_wr_en = 1'b1;
            px_in     = spot_next;
            rem_in    = rem_ff - CNT_W'(1);
            if (last_px) begin
               state_in = S_DONE;
            end
         end
         S_ADD_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_ADD_WR;
         end
         S_ADD_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = added;
            px_in       = spot_next;
            rem_in      = rem_ff - CNT_W'(1);
            state_in    = last_px ? S_DONE : S_ADD_RD;
         end
         S_READ: begin
            result_in = ram_rd_data;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {result_ff[7:0], result_ff[15:8], result_ff[23:16]};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, configuration and registered outputs
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      rem_ff      <= rem_in;
      colour_ff   <= colour_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= S_INIT;
         init_addr_ff   <= '0;
         ring_start_ff  <= '0;
         ring_length_ff <= RING_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         init_addr_ff   <= init_addr_in;
         ring_start_ff  <= ring_start_in;
         ring_length_ff <= ring_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/lrsr_ram.sv @@
// Generic single-clock RAM: one write port and one read port, read data registered.
// Depends on nothing; used for the pixel store.
module lrsr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lrsr_checker.sv @@
// Port-level checker for the LED ring spot renderer, bound to the top level.
// Depends on lrsr_pkg and the assertion macros in the defines header.
`include "led_ring_spot_renderer_unit_defines.svh"

module lrsr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [lrsr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [lrsr_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lrsr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [lrsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [lrsr_pkg::CSR_DATA_W-1:0]  csr_data
);

   import lrsr_pkg::*;

   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // Count requests taken whose response has not yet been transferred
   always_comb begin
      outstanding_in = outstanding_ff;
      case ({req_xfer, rsp_xfer})
         2'b10:   outstanding_in = outstanding_ff + 2'd1;
         2'b01:   outstanding_in = outstanding_ff - 2'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `LRSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response dropped or changed while stalled")
   `LRSR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer,
      !req_tready, "request taken while the previous one is still at work")
   `LRSR_ASSERT_NOW(a_init_pass, clock, reset, $fell(reset),
      !req_tready && !rsp_tvalid, "request port open or response shown before clearing")
   `LRSR_ASSERT_NOW(a_depth, clock, reset, 1'b1,
      outstanding_ff != 2'd3, "more than two requests without responses")
   `LRSR_ASSERT_NOW(a_no_invented, clock, reset, rsp_tvalid,
      outstanding_ff != 2'd0, "response without a request")

endmodule

bind led_ring_spot_renderer_unit lrsr_checker u_lrsr_checker (.*);

@@ dv/led_ring_spot_renderer_unit_tb.sv @@
// Self-checking testbench for led_ring_spot_renderer_unit: drives stream requests
// and ring settings, and checks every response against a shadow pixel store.
// Depends on lrsr_pkg and the renderer RTL only.
module led_ring_spot_renderer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrsr_pkg::*;

   localparam int RANDOM_PER_SETTING = 125;
   localparam int NUM_SETTINGS       = 9;
   localparam int HOLD_OFF_CYCLES    = 600;
   localparam int DRAIN_CYCLES       = 520;

   typedef struct {
      req_kind_type      kind;
      logic [15:0]       pos;
      logic [15:0]       width;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              blend_add;
      logic [CHAN_W-1:0] brightness;
      logic [7:0]        pixel_index;
   } render_req_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_rgb_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   hold_off = 1'b0;

   // Shadow of the block: pixel store and ring registers
   logic [PIX_W-1:0] shadow_store [STORE_DEPTH];
   int unsigned      ring_start_cfg  = 0;
   int unsigned      ring_length_cfg = 16;

   render_req_type pending_reqs [$];
   pixel_rgb_type  expected_pixels [$];
   render_req_type current_req;
   pixel_rgb_type  want_px;

   int unsigned accepted_count = 0;
   int unsigned rsp_count      = 0;
   int unsigned fault_count    = 0;
   int unsigned setting_count  = 0;
   int unsigned kind_count [4] = '{default: 0};
   int unsigned burst_left     = 0;
   int unsigned idle_gap       = 0;
   int unsigned stall_left     = 0;
   int unsigned stall_mode     = 0;
   logic        ready_roll;

   led_ring_spot_renderer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = '0;
   end

   task automatic note_fault(input string what);
      if (fault_count < 10) $display("mismatch: %s", what);
      fault_count++;
   endtask

   function automatic logic [CHAN_W-1:0] sat_chan(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      int unsigned s;
      s = a + b;
      return (s > 255) ? 8'hff : s[CHAN_W-1:0];
   endfunction

   task automatic fill_ring(input logic [PIX_W-1:0] colour);
      for (int unsigned k = 0; k < ring_length_cfg; k++)
         shadow_store[(ring_start_cfg + k) % STORE_DEPTH] = colour;
   endtask

   // Apply one request to the shadow store and queue the response it yields
   task automatic predict_render(input render_req_type it);
      int unsigned      offset, count, px, wrap_at, a;
      int unsigned      r, g, b;
      logic [PIX_W-1:0] cur;
      pixel_rgb_type    out_px;
      out_px = '{red: '0, green: '0, blue: '0};
      r = it.red;
      g = it.green;
      b = it.blue;
      kind_count[it.kind]++;
      case (it.kind)
         REQ_CLEAR: begin
            fill_ring('0);
         end
         REQ_SPOT: begin
            offset  = ((32'(it.pos) - (32'(it.width) >> 1)) & 32'hffff) >> POSITION_SHIFT;
            count   = 32'(it.width) >> POSITION_SHIFT;
            px      = ring_start_cfg + offset;
            wrap_at = ring_start_cfg + ring_length_cfg;
            for (int unsigned k = 0; k < count; k++) begin
               a = px % STORE_DEPTH;
               if (it.blend_add) begin
                  cur = shadow_store[a];
                  shadow_store[a] = {sat_chan(cur[23:16], it.red),
                                     sat_chan(cur[15:8], it.green),
                                     sat_chan(cur[7:0], it.blue)};
               end else begin
                  shadow_store[a] = {it.red, it.green, it.blue};
               end
               px++;
               if (px == wrap_at) px = ring_start_cfg;
            end
         end
         REQ_BACKGROUND: begin
            if (it.brightness < BRIGHT_FULL) begin
               r = (it.brightness * r) >> 8;
               g = (it.brightness * g) >> 8;
               b = (it.brightness * b) >> 8;
            end
            fill_ring({r[7:0], g[7:0], b[7:0]});
         end
         default: begin
            cur = shadow_store[it.pixel_index % STORE_DEPTH];
            out_px.red   = cur[23:16];
            out_px.green = cur[15:8];
            out_px.blue  = cur[7:0];
         end
      endcase
      expected_pixels.push_back(out_px);
   endtask

   function automatic render_req_type make_req(input req_kind_type kind,
                                            input logic [15:0] pos, input logic [15:0] width,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic add,
                                            input logic [7:0] bright, input logic [7:0] idx);
      render_req_type it;
      it.kind        = kind;
      it.pos         = pos;
      it.width       = width;
      it.red         = r;
      it.green       = g;
      it.blue        = b;
      it.blend_add   = add;
      it.brightness  = bright;
      it.pixel_index = idx;
      return it;
   endfunction

   // Channel value biased towards the saturation corners
   function automatic logic [7:0] pick_channel();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic render_req_type random_request();
      render_req_type it;
      int unsigned sel, span;
      sel = $urandom_range(0, 99);
      it.kind = (sel < 40) ? REQ_READ : (sel < 78) ? REQ_SPOT :
                (sel < 90) ? REQ_BACKGROUND : REQ_CLEAR;
      it.pos   = 16'($urandom_range(0, 65535));
      it.width = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'h3fff))
                                             : 16'($urandom_range(0, 65535));
      it.red       = pick_channel();
      it.green     = pick_channel();
      it.blue      = pick_channel();
      it.blend_add = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 7);
      it.brightness = (sel < 2) ? BRIGHT_FULL : (sel == 2) ? 8'h00
                                              : 8'($urandom_range(0, 255));
      // Read around the segment half the time so that drawn pixels get seen
      span = (ring_length_cfg > 256) ? 256 : ring_length_cfg;
      if ($urandom_range(0, 1) == 0)
         it.pixel_index = 8'((ring_start_cfg + $urandom_range(0, span + 16)) % STORE_DEPTH);
      else
         it.pixel_index = 8'($urandom_range(0, 255));
      return it;
   endfunction

   task automatic csr_write(input csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_RING_START) ring_start_cfg = value & 32'hff;
      else ring_length_cfg = value & 32'h1ff;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_pixels.size() != 0);
   endtask

   // Request driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_render(current_req);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (idle_gap > 0 || pending_reqs.size() == 0) begin
               if (idle_gap > 0) idle_gap--;
               req_tvalid <= 1'b0;
            end else begin
               current_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= current_req.kind;
               req_tdata  <= {7'b0, current_req.pixel_index, current_req.brightness,
                              current_req.blend_add, current_req.blue, current_req.green,
                              current_req.red, current_req.width, current_req.pos};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
      end
   end

   // Response ready: drawn from one of four stall patterns, picked anew at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_left = $urandom_range(16, 96);
            stall_mode = $urandom_range(0, 3);
         end
         stall_left--;
         case (stall_mode)
            0: ready_roll = 1'b1;
            1: ready_roll = 1'($urandom_range(0, 1));
            2: ready_roll = ($urandom_range(0, 3) == 0);
            default: ready_roll = ((stall_left % 8) < 5);
         endcase
         rsp_tready <= ready_roll && !hold_off;
      end
   end

   // Response monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_pixels.size() == 0) begin
            note_fault($sformatf("response %0d with nothing outstanding, tdata=%06h",
                                 rsp_count, rsp_tdata));
         end else begin
            want_px = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== want_px.red || rsp_tdata[15:8] !== want_px.green ||
                rsp_tdata[23:16] !== want_px.blue)
               note_fault($sformatf({"response %0d: expected r=%02h g=%02h b=%02h, ",
                                     "got r=%02h g=%02h b=%02h"}, rsp_count,
                                    want_px.red, want_px.green, want_px.blue,
                                    rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]));
         end
      end
   end

   // Long response hold-off mid-run so that the block backs up onto its input
   initial begin
      wait (accepted_count >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #40_000_000;
      $display("timeout: %0d requests accepted, %0d responses seen", accepted_count, rsp_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus: directed checks at reset settings, then random runs per ring setting
   initial begin
      int unsigned seg_start  [NUM_SETTINGS];
      int unsigned seg_length [NUM_SETTINGS];
      seg_start  = '{250, 0, 255, 100, 7, 200, 37, 0, 128};
      seg_length = '{16, 4, 1, 256, 0, 511, 100, 3, 60};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Rewrite the reset values while the clearing pass runs
      csr_write(CSR_RING_START, 0);
      csr_write(CSR_RING_LENGTH, 16);
      setting_count++;

      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0));
      pending_reqs.push_back(make_req(REQ_BACKGROUND, 0, 0, 8'hff, 8'h80, 8'h01, 0,
                                      BRIGHT_FULL, 0));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd15));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd16));
      pending_reqs.push_back(make_req(REQ_SPOT, 16'h8000, 16'h4000, 8'h12, 8'h34, 8'h56,
                                      0, 0, 0));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd6));
      // Widest spot, adding: saturates red and wraps round the segment end
      pending_reqs.push_back(make_req(REQ_SPOT, 16'hffff, 16'hffff, 8'hff, 8'h01, 8'h00,
                                      1, 0, 0));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd8));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0));
      pending_reqs.push_back(make_req(REQ_SPOT, 16'h1234, 16'h0000, 8'hee, 8'hee, 8'hee,
                                      0, 0, 0));
      // Start offset underflows to the last pixel, then wraps to the first
      pending_reqs.push_back(make_req(REQ_SPOT, 16'h0000, 16'h2000, 8'h0a, 8'h0b, 8'h0c,
                                      0, 0, 0));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd15));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0));
      pending_reqs.push_back(make_req(REQ_BACKGROUND, 0, 0, 8'hff, 8'hff, 8'hff, 0,
                                      8'h00, 0));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd3));
      pending_reqs.push_back(make_req(REQ_BACKGROUND, 0, 0, 8'hff, 8'h80, 8'h02, 0,
                                      8'h80, 0));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd5));
      pending_reqs.push_back(make_req(REQ_SPOT, 16'h3000, 16'h1000, 8'h80, 8'hff, 8'hff,
                                      1, 0, 0));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd2));
      pending_reqs.push_back(make_req(REQ_CLEAR, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff,
                                      1, 8'hff, 8'hff));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd2));
      pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255));
      wait_idle();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         csr_write(CSR_RING_START, seg_start[s]);
         csr_write(CSR_RING_LENGTH, seg_length[s]);
         setting_count++;
         for (int k = 0; k < RANDOM_PER_SETTING; k++) pending_reqs.push_back(random_request());
         wait_idle();
      end

      // Allow a stray late response to show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0)
         note_fault($sformatf("%0d responses never arrived", expected_pixels.size()));

      $display("covered %0d requests (clear %0d, spot %0d, background %0d, read %0d)",
               accepted_count, kind_count[REQ_CLEAR], kind_count[REQ_SPOT],
               kind_count[REQ_BACKGROUND], kind_count[REQ_READ]);
      $display("over %0d ring settings; %0d responses checked, %0d mismatches",
               setting_count, rsp_count, fault_count);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lrsr_pkg.sv
hw/rtl/lrsr_ram.sv
hw/rtl/led_ring_spot_renderer_unit.sv
hw/rtl/lrsr_checker.sv
dv/led_ring_spot_renderer_unit_tb.sv
